FILE: rtl/vfc_pkg.sv
// Package for the VAX float format converter: payload structs, request and status codes.
// No dependencies.
`default_nettype none
package vfc_pkg;
    localparam logic [2:0] REQ_UNPACK_F = 3'd0;
    localparam logic [2:0] REQ_UNPACK_D = 3'd1;
    localparam logic [2:0] REQ_PACK_F   = 3'd2;
    localparam logic [2:0] REQ_PACK_D   = 3'd3;
    localparam logic [2:0] REQ_SHORT    = 3'd4;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_RSV = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;
    localparam logic [1:0] ST_UNF = 2'd3;

    // Largest double magnitude that is not above 8.0e37 (magnitude bits).
    localparam logic [62:0] MAG_LIMIT = 63'h47CE_17B8_4357_691B;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] vax_lo;
        logic [31:0] vax_hi;
        logic [63:0] ieee_value;
        logic [5:0]  short_literal;
    } t_in;

    typedef struct packed {
        logic [63:0] ieee_result;
        logic [31:0] vax_out_lo;
        logic [31:0] vax_out_hi;
        logic [1:0]  status;
    } t_out;
endpackage
`default_nettype wire

FILE: rtl/vfc_core.sv
// Combinational conversion for one word: unpack, pack and short-literal expansion.
// Depends on vfc_pkg.
`default_nettype none
module vfc_core (
    input  var vfc_pkg::t_in  i_word,
    output var vfc_pkg::t_out o_word
);
    logic        u_sign;
    logic [7:0]  u_ex;
    logic [10:0] u_e;
    logic [55:0] u_sig;
    logic [53:0] u_q;
    logic        u_up;
    logic [63:0] u_f, u_d;

    logic        p_sign;
    logic [10:0] p_be;
    logic [51:0] p_m;
    logic [62:0] p_mag;
    logic [11:0] p_vexp;
    logic [24:0] p_raw;
    logic [8:0]  p_fexp;
    logic [22:0] p_ffrac;
    logic [1:0]  p_st;
    logic [31:0] p_flo, p_dlo, p_dhi;
    logic        p_ovf_f;

    always_comb begin
        u_sign = i_word.vax_lo[15];
        u_ex   = i_word.vax_lo[14:7];
        u_e    = {3'b000, u_ex} + 11'd894;
        u_f    = {u_sign, u_e, i_word.vax_lo[6:0], i_word.vax_lo[31:16], 29'd0};
        u_sig  = {1'b1, i_word.vax_lo[6:0], i_word.vax_lo[31:16], i_word.vax_hi};
        // Round to nearest even on the three dropped bits.
        u_up   = u_sig[2] & (u_sig[1] | u_sig[0] | u_sig[3]);
        u_q    = {1'b0, u_sig[55:3]} + {53'd0, u_up};
        if (u_q[53]) begin
            u_d = {u_sign, u_e + 11'd1, u_q[52:1]};
        end else begin
            u_d = {u_sign, u_e, u_q[51:0]};
        end

        p_sign = i_word.ieee_value[63];
        p_be   = i_word.ieee_value[62:52];
        p_m    = i_word.ieee_value[51:0];
        p_mag  = i_word.ieee_value[62:0];
        p_vexp = {1'b0, p_be} - 12'd894;
        // Half-up rounding to 24 significant bits.
        p_raw  = {1'b0, 1'b1, p_m[51:29]} + {24'd0, p_m[28]};
        if (p_raw[24]) begin
            p_fexp  = {1'b0, p_vexp[7:0]} + 9'd1;
            p_ffrac = p_raw[23:1];
        end else begin
            p_fexp  = {1'b0, p_vexp[7:0]};
            p_ffrac = p_raw[22:0];
        end
        p_ovf_f = p_fexp[8];
        p_flo = {p_ffrac[15:0], p_sign, p_fexp[7:0], p_ffrac[22:16]};
        p_dlo = {p_m[44:29], p_sign, p_vexp[7:0], p_m[51:45]};
        p_dhi = {p_m[28:0], 3'b000};
        if (p_be == 11'h7FF || p_mag > vfc_pkg::MAG_LIMIT) begin
            p_st = vfc_pkg::ST_OVF;
        end else if (p_mag == 63'd0) begin
            p_st = vfc_pkg::ST_OK;
        end else if (p_be <= 11'd894) begin
            p_st = vfc_pkg::ST_UNF;
        end else begin
            p_st = vfc_pkg::ST_OK;
        end

        o_word = '0;
        case (i_word.req_type)
            vfc_pkg::REQ_UNPACK_F, vfc_pkg::REQ_UNPACK_D: begin
                if (u_ex == 8'd0) begin
                    o_word.status = u_sign ? vfc_pkg::ST_RSV : vfc_pkg::ST_OK;
                end else begin
                    o_word.ieee_result =
                        (i_word.req_type == vfc_pkg::REQ_UNPACK_D) ? u_d : u_f;
                end
            end
            vfc_pkg::REQ_PACK_F: begin
                if (p_st == vfc_pkg::ST_OK && p_mag != 63'd0 && p_ovf_f) begin
                    o_word.status = vfc_pkg::ST_OVF;
                end else begin
                    o_word.status = p_st;
                    if (p_st == vfc_pkg::ST_OK && p_mag != 63'd0) begin
                        o_word.vax_out_lo = p_flo;
                    end
                end
            end
            vfc_pkg::REQ_PACK_D: begin
                o_word.status = p_st;
                if (p_st == vfc_pkg::ST_OK && p_mag != 63'd0) begin
                    o_word.vax_out_lo = p_dlo;
                    o_word.vax_out_hi = p_dhi;
                end
            end
            vfc_pkg::REQ_SHORT: begin
                o_word.vax_out_lo = {16'd0, 1'b0, 5'd16, i_word.short_literal[5:3],
                                     i_word.short_literal[2:0], 4'd0};
            end
            default: begin
                o_word = '0;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/vax_float_format_converter_top.sv
// Top level of the VAX float format converter: combinational conversion, result register.
// Depends on vfc_pkg and vfc_core.
// Output: an accepted word is held in the result register and offered at the output.
// Throughput: one word per cycle while the output is not stalled; the conversion is at most one rounding add per path.
// Reset: synchronous, active low; it clears the valid flag, payloads are not reset.
`default_nettype none
module vax_float_format_converter_top (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          i_valid,
    output var logic          o_ready,
    input  var vfc_pkg::t_in  i_data,
    output var logic          o_valid,
    input  var logic          i_ready,
    output var vfc_pkg::t_out o_data
);
    // The input word is converted combinationally and captured in the result
    // register. The register takes a new word whenever it is empty or its
    // current word leaves in the same cycle, so full rate holds under no stall.
    vfc_pkg::t_out w_conv;
    vfc_pkg::t_out r_data, n_data;
    logic          r_valid, n_valid;

    vfc_core u_core (
        .i_word (i_data),
        .o_word (w_conv)
    );

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (o_ready) begin
            n_valid = i_valid;
            n_data  = w_conv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("accepted word lost");
    a_unpack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != vfc_pkg::ST_OK |-> o_data.ieee_result == 64'd0)
        else $error("nonzero result with bad status");
endmodule
`default_nettype wire
